// ----- hdl/mtam_pkg.sv -----
// shared constants and control types for the matrix engine
package mtam_pkg;

  localparam int DEF_MAX_DIM = 16;

  localparam int DIM_W  = 5;
  localparam int IDX_W  = 4;
  localparam int ELEM_W = 16;
  localparam int RES_W  = 36;
  localparam int TERM_W = 33;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 5;

  // item opcodes
  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_READ = 1'b1;

  // load target
  localparam logic SEL_A = 1'b0;
  localparam logic SEL_B = 1'b1;

  // configured operation
  localparam logic [1:0] OP_TRANSPOSE = 2'd0;
  localparam logic [1:0] OP_ADD       = 2'd1;
  localparam logic [1:0] OP_MUL       = 2'd2;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIM   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS_A    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLS_A    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS_B    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLS_B    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_OPERATION = 3'd4;

  typedef struct packed {
    logic capture;
    logic check;
    logic issue;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic compute;
    logic issue_last;
    logic acc_done;
  } sts_t;

endpackage

// ----- hdl/mtam_ctrl.sv -----
// sequencer: item accept, check, issue of operand reads, drain and result hand-off
module mtam_ctrl
  import mtam_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_ISSUE = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd.capture  = 1'b0;
    cmd.check    = 1'b0;
    cmd.issue    = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = sts.compute ? S_ISSUE : S_DONE;
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (sts.issue_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.acc_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/mtam_dp.sv -----
// datapath: configuration, element stores, shared multiply-accumulate, result register
module mtam_dp
  import mtam_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM
)
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          opcode,
  input  logic                          matrix_select,
  input  logic [IDX_W-1:0]              row,
  input  logic [IDX_W-1:0]              col,
  input  logic signed [ELEM_W-1:0]      value,
  input  cmd_t                          cmd,
  output sts_t                          sts,
  output logic signed [RES_W-1:0]       result_value,
  output logic [1:0]                    status
);

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIM_CAP = (MAX_DIM > 31) ? 31 : MAX_DIM;
  localparam logic [DIM_W-1:0] DIM_SAT = DIM_W'(DIM_CAP);

  // configuration
  logic [DIM_W-1:0] rows_a, cols_a, rows_b, cols_b;
  logic [1:0]       operation;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_W'(1);
      cols_a    <= DIM_W'(1);
      rows_b    <= DIM_W'(1);
      cols_b    <= DIM_W'(1);
      operation <= OP_TRANSPOSE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROWS_A:    rows_a    <= cfg_data;
        CFG_COLS_A:    cols_a    <= cfg_data;
        CFG_ROWS_B:    rows_b    <= cfg_data;
        CFG_COLS_B:    cols_b    <= cfg_data;
        CFG_OPERATION: operation <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] ra_e, ca_e, rb_e, cb_e;
  assign ra_e = (rows_a > DIM_SAT) ? DIM_SAT : rows_a;
  assign ca_e = (cols_a > DIM_SAT) ? DIM_SAT : cols_a;
  assign rb_e = (rows_b > DIM_SAT) ? DIM_SAT : rows_b;
  assign cb_e = (cols_b > DIM_SAT) ? DIM_SAT : cols_b;

  // item capture
  logic                     opc_q, sel_q;
  logic [IDX_W-1:0]         row_q, col_q;
  logic signed [ELEM_W-1:0] val_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      opc_q <= opcode;
      sel_q <= matrix_select;
      row_q <= row;
      col_q <= col;
      val_q <= value;
    end
  end

  // status of the item
  logic             dim_bad, load_oob;
  logic [DIM_W-1:0] sr, sc;
  logic [1:0]       st_calc, st_q;

  assign load_oob = (32'(row_q) >= 32'(MAX_DIM)) || (32'(col_q) >= 32'(MAX_DIM));

  always_comb begin
    dim_bad = 1'b0;
    sr      = ca_e;
    sc      = ra_e;
    unique case (operation)
      OP_TRANSPOSE: begin
        sr = ca_e;
        sc = ra_e;
      end
      OP_ADD: begin
        dim_bad = (ra_e != rb_e) || (ca_e != cb_e);
        sr      = ra_e;
        sc      = ca_e;
      end
      OP_MUL: begin
        dim_bad = (ca_e != rb_e);
        sr      = ra_e;
        sc      = cb_e;
      end
      default: begin
        dim_bad = 1'b1;
      end
    endcase
    if (opc_q == OPC_LOAD) begin
      st_calc = load_oob ? ST_RANGE : ST_OK;
    end else if (dim_bad) begin
      st_calc = ST_DIM;
    end else if ({1'b0, row_q} >= sr || {1'b0, col_q} >= sc) begin
      st_calc = ST_RANGE;
    end else begin
      st_calc = ST_OK;
    end
  end

  // empty inner dimension leaves the cleared sum as the result
  assign sts.compute = (opc_q == OPC_READ) && (st_calc == ST_OK)
                       && !(operation == OP_MUL && ca_e == '0);

  // operand sequencing
  logic [DIM_W-1:0] k;
  assign sts.issue_last = (operation != OP_MUL) || (k == DIM_W'(ca_e - DIM_W'(1)));

  logic [ADDR_W-1:0] addr_a, addr_b, w_addr;
  logic              wr_en;

  assign w_addr = ADDR_W'(32'(row_q) * MAX_DIM + 32'(col_q));
  assign wr_en  = cmd.check && (opc_q == OPC_LOAD) && !load_oob;

  always_comb begin
    unique case (operation)
      OP_TRANSPOSE: begin
        addr_a = ADDR_W'(32'(col_q) * MAX_DIM + 32'(row_q));
        addr_b = addr_a;
      end
      OP_ADD: begin
        addr_a = w_addr;
        addr_b = w_addr;
      end
      default: begin
        addr_a = ADDR_W'(32'(row_q) * MAX_DIM + 32'(k));
        addr_b = ADDR_W'(32'(k) * MAX_DIM + 32'(col_q));
      end
    endcase
  end

  // element stores
  logic signed [ELEM_W-1:0] store_a [DEPTH];
  logic signed [ELEM_W-1:0] store_b [DEPTH];
  logic signed [ELEM_W-1:0] a_q, b_q;

  always_ff @(posedge clk) begin
    if (wr_en && sel_q == SEL_A) begin
      store_a[w_addr] <= val_q;
    end
    if (cmd.issue) begin
      a_q <= store_a[addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && sel_q == SEL_B) begin
      store_b[w_addr] <= val_q;
    end
    if (cmd.issue) begin
      b_q <= store_b[addr_b];
    end
  end

  // read -> term -> accumulate
  logic                     rd_vld, rd_last, term_vld, term_last, acc_done;
  logic signed [TERM_W-1:0] term;
  logic signed [RES_W-1:0]  acc;

  assign sts.acc_done = acc_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld    <= 1'b0;
      rd_last   <= 1'b0;
      term_vld  <= 1'b0;
      term_last <= 1'b0;
      acc_done  <= 1'b0;
      k         <= '0;
    end else begin
      rd_vld    <= cmd.issue;
      rd_last   <= cmd.issue && sts.issue_last;
      term_vld  <= rd_vld;
      term_last <= rd_last;
      if (cmd.check) begin
        k        <= '0;
        acc_done <= 1'b0;
      end else begin
        if (cmd.issue) begin
          k <= k + DIM_W'(1);
        end
        if (term_vld && term_last) begin
          acc_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      case (operation)
        OP_TRANSPOSE: term <= TERM_W'(a_q);
        OP_ADD:       term <= TERM_W'(a_q) + TERM_W'(b_q);
        default:      term <= TERM_W'(32'(a_q) * 32'(b_q));
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      acc  <= '0;
      st_q <= st_calc;
    end else if (term_vld) begin
      acc <= acc + RES_W'(term);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result_value <= acc;
      status       <= st_q;
    end
  end

endmodule

// ----- hdl/matrix_transpose_add_multiply.sv -----
// top level of the integer matrix engine: transpose, add and multiply of two stores
//
//   channel   handshake               beat carries
//   in        in_valid / in_ready     opcode, matrix_select, row, col, value
//   out       out_valid / out_ready   result_value, status
//   cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one item at a time: accept, check, operand reads, drain, then result hand-off
// loads and rejected reads skip the operand reads and go from check to hand-off
// transpose and add issue one read, multiply issues cols_a reads with cols_a capped
// at MAX_DIM (none when cols_a is zero), one product per cycle into the multiply-accumulate
// a new item is taken while the previous result still waits in the output register
// synchronous reset clears control and configuration; element stores are not cleared
module matrix_transpose_add_multiply
  import mtam_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM
)
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     opcode,
  input  logic                     matrix_select,
  input  logic [IDX_W-1:0]         row,
  input  logic [IDX_W-1:0]         col,
  input  logic signed [ELEM_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [RES_W-1:0]  result_value,
  output logic [1:0]               status,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  mtam_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mtam_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .opcode        (opcode),
    .matrix_select (matrix_select),
    .row           (row),
    .col           (col),
    .value         (value),
    .cmd           (cmd),
    .sts           (sts),
    .result_value  (result_value),
    .status        (status)
  );

endmodule
